// File: src/ppd_pkg.sv
`timescale 1ns / 1ps
package ppd_pkg;
  localparam int TableDepth  = 16;
  localparam int MaxDispatch = 32;
  localparam int IdxW        = $clog2(TableDepth);
  localparam int CntW        = $clog2(TableDepth + 1);
  localparam int DispW       = $clog2(MaxDispatch + 1);

  typedef enum logic {
    KIND_ADD  = 1'b0,
    KIND_TICK = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DISP,
    ST_LOOK,
    ST_EMPTY,
    ST_OUT
  } state_e;

  // Candidate that moves along the cell chain
  typedef struct packed {
    logic            found;
    logic [IdxW-1:0] idx;
    logic [7:0]      prio;
  } cand_t;

  // Control from the sequencer to every cell
  typedef struct packed {
    logic            load;
    logic            upd;
    logic            late;
    logic [IdxW-1:0] sel;
    logic [31:0]     period;
    logic [7:0]      prio;
    logic [31:0]     now;
    logic [CntW-1:0] used;
  } cell_ctl_t;
endpackage

// File: src/ppd_cell.sv
`timescale 1ns / 1ps
module ppd_cell (
  input  logic                      clk_i,
  input  logic [ppd_pkg::IdxW-1:0]  idx_i,
  input  ppd_pkg::cell_ctl_t        ctl_i,
  input  ppd_pkg::cand_t            cand_i,
  output ppd_pkg::cand_t            cand_o,
  output logic [31:0]               deadline_o,
  output logic [31:0]               period_o,
  output logic [31:0]               runs_o,
  output logic [31:0]               overs_o
);
  logic [31:0] period_q, deadline_q, runs_q, overs_q;
  logic [7:0]  prio_q;
  logic        due;

  // Compare this entry against the candidate handed in by the left neighbor
  always_comb begin
    due = ({1'b0, idx_i} < ctl_i.used) && (ctl_i.now >= deadline_q);
    cand_o = cand_i;
    if (due && (!cand_i.found || prio_q < cand_i.prio)) begin
      cand_o.found = 1'b1;
      cand_o.idx   = idx_i;
      cand_o.prio  = prio_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load && ctl_i.sel == idx_i) begin
      period_q   <= ctl_i.period;
      deadline_q <= ctl_i.period;
      prio_q     <= ctl_i.prio;
      runs_q     <= '0;
      overs_q    <= '0;
    end else if (ctl_i.upd && ctl_i.sel == idx_i) begin
      runs_q     <= runs_q + 32'd1;
      overs_q    <= overs_q + {31'd0, ctl_i.late};
      deadline_q <= deadline_q + period_q;
    end
  end

  assign deadline_o = deadline_q;
  assign period_o   = period_q;
  assign runs_o     = runs_q;
  assign overs_o    = overs_q;
endmodule

// File: src/ppd_chain.sv
`timescale 1ns / 1ps
module ppd_chain (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ppd_pkg::cell_ctl_t       ctl_i,
  input  logic                     start_i,
  output logic                     done_o,
  output ppd_pkg::cand_t           best_o,
  output logic [31:0]              deadline_o,
  output logic [31:0]              period_o,
  output logic [31:0]              runs_o,
  output logic [31:0]              overs_o
);
  localparam int N = ppd_pkg::TableDepth;
  ppd_pkg::cand_t cand [N+1];
  ppd_pkg::cand_t stage_q [N];
  logic [N-1:0]   vld_q;
  logic [31:0] dl [N];
  logic [31:0] pr [N];
  logic [31:0] rn [N];
  logic [31:0] ov [N];

  // Each cell registers its candidate; the scan ripples one cell per cycle
  for (genvar g = 0; g < N; g++) begin : g_cell
    ppd_pkg::cand_t cin;
    assign cin = (g == 0) ? '0 : stage_q[(g == 0) ? 0 : g-1];
    ppd_cell u_cell (
      .clk_i, .idx_i(ppd_pkg::IdxW'(g)), .ctl_i, .cand_i(cin),
      .cand_o(cand[g]), .deadline_o(dl[g]), .period_o(pr[g]),
      .runs_o(rn[g]), .overs_o(ov[g])
    );
    always_ff @(posedge clk_i) stage_q[g] <= cand[g];
  end
  assign cand[N] = stage_q[N-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[N-2:0], start_i};
    end
  end

  assign done_o     = vld_q[N-1];
  assign best_o     = cand[N];
  assign deadline_o = dl[cand[N].idx];
  assign period_o   = pr[cand[N].idx];
  assign runs_o     = rn[cand[N].idx];
  assign overs_o    = ov[cand[N].idx];

`ifndef SYNTHESIS
  a_one_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(vld_q) <= 1) else $error("overlapping scans");
  a_done_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(vld_q[N-2])) else $error("done without scan");
  a_best_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && best_o.found) |-> ({1'b0, best_o.idx} < ctl_i.used))
    else $error("winner outside table");
`endif
endmodule

// File: src/periodic_priority_task_dispatcher_top.sv
`timescale 1ns / 1ps
// Periodic priority task dispatcher.
// Slave channel s_axis_*: one transaction is an add (tuser = 0) carrying a
// priority and a period, or a tick (tuser = 1) that advances the 32-bit time.
// Master channel m_axis_*: add gives one result; a tick gives one result per
// dispatched task (up to 32), or one empty result if nothing is due; tlast
// marks the final result of each input transaction.
// Tasks live in a chain of 16 cells; a scan shifts a candidate through the
// chain one cell per cycle. Each dispatch takes its own scan, an issue step
// and a lookahead scan that decides tlast before its result is output; the
// 32nd dispatch of a tick skips the lookahead. An empty tick answers after
// its one scan and an empty step, an add answers without any scan, and the
// next input transaction can be accepted in the cycle after the final
// result of the previous transaction was taken.
// One input transaction is handled at a time: s_axis_tready is high only
// while idle. When the receiver stalls, the result is held in the output
// register and the sequencer waits. Reset clears time, task count and the
// sequencer; table contents are only read after their add has written them.
module periodic_priority_task_dispatcher_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [15:0] step_ms, [23:16] task_priority, [55:24] task_period
  input  logic [55:0] s_axis_tdata,
  // [0] kind
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] accepted, [1] dispatched, [5:2] task_index, [6] late,
  // [38:7] runs_so_far, [70:39] overruns_so_far, [102:71] time_now, pad
  output logic [103:0] m_axis_tdata,
  output logic        m_axis_tlast
);
  ppd_pkg::state_e state_q, state_d;
  logic [31:0] time_q, time_d;
  logic [ppd_pkg::CntW-1:0]  used_q, used_d;
  logic [ppd_pkg::DispW-1:0] ndisp_q, ndisp_d;
  logic [103:0] res_q, res_d;
  logic last_q, last_d;
  ppd_pkg::cell_ctl_t ctl;
  logic start, done;
  ppd_pkg::cand_t best;
  logic [31:0] b_dl, b_pr, b_rn, b_ov;
  logic late;
  logic s_fire, m_fire, full;

  assign s_fire = s_axis_tvalid && s_axis_tready;
  assign m_fire = m_axis_tvalid && m_axis_tready;
  assign full   = used_q >= ppd_pkg::CntW'(ppd_pkg::TableDepth);
  assign late   = time_q > (b_dl + b_pr);

  ppd_chain u_chain (
    .clk_i, .rst_ni, .ctl_i(ctl), .start_i(start), .done_o(done),
    .best_o(best), .deadline_o(b_dl), .period_o(b_pr), .runs_o(b_rn),
    .overs_o(b_ov)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ppd_pkg::ST_IDLE: begin
        if (s_fire) begin
          state_d = (s_axis_tuser == ppd_pkg::KIND_TICK) ? ppd_pkg::ST_SCAN
                                                        : ppd_pkg::ST_OUT;
        end
      end
      ppd_pkg::ST_SCAN: begin
        if (done) begin
          if (best.found) state_d = ppd_pkg::ST_DISP;
          else if (ndisp_q == '0) state_d = ppd_pkg::ST_EMPTY;
          else state_d = ppd_pkg::ST_IDLE;
        end
      end
      ppd_pkg::ST_DISP: begin
        state_d = (ndisp_q >= ppd_pkg::DispW'(ppd_pkg::MaxDispatch)) ? ppd_pkg::ST_OUT
                                                                     : ppd_pkg::ST_LOOK;
      end
      ppd_pkg::ST_LOOK: begin
        if (done) state_d = ppd_pkg::ST_OUT;
      end
      ppd_pkg::ST_EMPTY: state_d = ppd_pkg::ST_OUT;
      ppd_pkg::ST_OUT: begin
        if (m_fire) state_d = last_q ? ppd_pkg::ST_IDLE : ppd_pkg::ST_SCAN;
      end
      default: state_d = ppd_pkg::ST_IDLE;
    endcase
  end

  // Outputs and datapath
  always_comb begin
    time_d  = time_q;
    used_d  = used_q;
    ndisp_d = ndisp_q;
    res_d   = res_q;
    last_d  = last_q;
    start   = 1'b0;
    ctl     = '0;
    ctl.now  = time_q;
    ctl.used = used_q;
    ctl.sel  = best.idx;
    ctl.late = late;
    ctl.period = s_axis_tdata[55:24];
    ctl.prio   = s_axis_tdata[23:16];
    case (state_q)
      ppd_pkg::ST_IDLE: begin
        if (s_fire) begin
          ndisp_d = '0;
          if (s_axis_tuser == ppd_pkg::KIND_TICK) begin
            time_d = time_q + {16'd0, s_axis_tdata[15:0]};
            // The first cell compares in this cycle, so hand it the new time
            ctl.now = time_d;
            start  = 1'b1;
          end else begin
            res_d  = '0;
            last_d = 1'b1;
            res_d[102:71] = time_q;
            if (!full) begin
              ctl.load = 1'b1;
              ctl.sel  = used_q[ppd_pkg::IdxW-1:0];
              res_d[0] = 1'b1;
              res_d[5:2] = 4'(used_q);
              used_d = used_q + 1'b1;
            end
          end
        end
      end
      ppd_pkg::ST_SCAN: begin
        if (done && best.found) begin
          ctl.upd = 1'b1;
          res_d   = '0;
          res_d[1] = 1'b1;
          res_d[5:2] = 4'(best.idx);
          res_d[6] = late;
          res_d[38:7]  = b_rn + 32'd1;
          res_d[70:39] = b_ov + {31'd0, late};
          res_d[102:71] = time_q;
          ndisp_d = ndisp_q + 1'b1;
        end else if (done && ndisp_q == '0) begin
          res_d = '0;
          res_d[102:71] = time_q;
          last_d = 1'b1;
        end
      end
      ppd_pkg::ST_DISP: begin
        // End the tick at the cap, else run a lookahead scan over the
        // updated table to decide whether this dispatch is the last one.
        last_d = ndisp_q >= ppd_pkg::DispW'(ppd_pkg::MaxDispatch);
        start  = !last_d;
      end
      ppd_pkg::ST_LOOK: begin
        // Nothing left due: the held dispatch closes the tick
        if (done) last_d = !best.found;
      end
      ppd_pkg::ST_OUT: begin
        if (m_fire && !last_q) start = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ppd_pkg::ST_IDLE;
      time_q  <= '0;
      used_q  <= '0;
      ndisp_q <= '0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      time_q  <= time_d;
      used_q  <= used_d;
      ndisp_q <= ndisp_d;
      last_q  <= last_d;
    end
  end

  always_ff @(posedge clk_i) res_q <= res_d;

  assign s_axis_tready = state_q == ppd_pkg::ST_IDLE;
  assign m_axis_tvalid = state_q == ppd_pkg::ST_OUT;
  assign m_axis_tdata  = res_q;
  assign m_axis_tlast  = last_q;

`ifndef SYNTHESIS
  a_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ndisp_q <= ppd_pkg::DispW'(ppd_pkg::MaxDispatch)) else $error("cap exceeded");
  a_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= ppd_pkg::CntW'(ppd_pkg::TableDepth)) else $error("table overflow");
  a_idle_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !m_axis_tvalid) else $error("output while idle");
`endif
endmodule
